/* rtl/core/mcst_pkg.sv */
// ----------------------------------------------------------------------------
// mcst_pkg
// Shared constants, codes and controller/datapath interface types for the
// MIDI channel state tracker.
// ----------------------------------------------------------------------------
package mcst_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int NOTES_PER_CH     = 128;
    localparam int HALF_W           = 64;
    localparam int CNT_W            = 12;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 1;
    localparam int POP_W            = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_NOTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_CONTROLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_PROGRAMS = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_NOTE     = 3'd0;
    localparam logic [2:0] KIND_CTRL     = 3'd1;
    localparam logic [2:0] KIND_PROGRAM  = 3'd2;
    localparam logic [2:0] KIND_BEND     = 3'd3;
    localparam logic [2:0] KIND_PRESSURE = 3'd4;
    localparam logic [2:0] KIND_OFF_MASK = 3'd5;

    // decoded operations
    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_NOTE_ON  = 3'd1;
    localparam logic [2:0] OP_NOTE_OFF = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_BEND     = 3'd4;
    localparam logic [2:0] OP_PRESS    = 3'd5;
    localparam logic [2:0] OP_PROG     = 3'd6;
    localparam logic [2:0] OP_CTRL     = 3'd7;

    // status byte message types (high nibble)
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CTRL     = 4'hB;
    localparam logic [3:0] MSG_PROG     = 4'hC;
    localparam logic [3:0] MSG_PRESS    = 4'hD;
    localparam logic [3:0] MSG_BEND     = 4'hE;

    localparam logic [6:0] CC_SUSTAIN       = 7'd64;
    localparam logic [6:0] CC_HOLD2         = 7'd69;
    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

    localparam logic [13:0] BEND_CENTRE = 14'd8192;

    typedef struct packed {
        logic accept;
        logic rd;
        logic eval;
        logic put;
        logic clr_rd1;
        logic clr_cap;
        logic pop;
        logic put_lo;
        logic put_hi;
        logic init;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic op_none;
        logic op_clear;
        logic changed;
        logic pop_last;
        logic mask_lo_nz;
        logic mask_hi_nz;
        logic out_free;
    } t_stat;

endpackage

/* rtl/core/mcst_ctrl.sv */
// ----------------------------------------------------------------------------
// mcst_ctrl
// Sequencer for the tracker: controller memory initialisation, per-message
// read / evaluate / result steps and the channel clear sequence.
// ----------------------------------------------------------------------------
module mcst_ctrl
    import mcst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_stall
);

    localparam logic [3:0] ST_INIT    = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_READ    = 4'd2;
    localparam logic [3:0] ST_EVAL    = 4'd3;
    localparam logic [3:0] ST_PUT     = 4'd4;
    localparam logic [3:0] ST_CLR_RD1 = 4'd5;
    localparam logic [3:0] ST_CLR_CAP = 4'd6;
    localparam logic [3:0] ST_CLR_POP = 4'd7;
    localparam logic [3:0] ST_CLR_LO  = 4'd8;
    localparam logic [3:0] ST_CLR_HI  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init = 1'b1;
                if (i_stat.init_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                if (i_stat.op_none) begin
                    n_state = ST_IDLE;
                end else if (i_stat.op_clear) begin
                    n_state = ST_CLR_RD1;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.changed ? ST_PUT : ST_IDLE;
            end
            ST_PUT: begin
                o_cmd.put = i_stat.out_free;
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_CLR_RD1: begin
                o_cmd.clr_rd1 = 1'b1;
                n_state       = ST_CLR_CAP;
            end
            ST_CLR_CAP: begin
                o_cmd.clr_cap = 1'b1;
                n_state       = ST_CLR_POP;
            end
            ST_CLR_POP: begin
                o_cmd.pop = 1'b1;
                if (i_stat.pop_last) n_state = ST_CLR_LO;
            end
            ST_CLR_LO: begin
                // lower half mask goes out only if some note of it was on
                if (!i_stat.mask_lo_nz) begin
                    n_state = i_stat.mask_hi_nz ? ST_CLR_HI : ST_IDLE;
                end else begin
                    o_cmd.put_lo = i_stat.out_free;
                    if (i_stat.out_free) n_state = i_stat.mask_hi_nz ? ST_CLR_HI : ST_IDLE;
                end
            end
            ST_CLR_HI: begin
                o_cmd.put_hi = i_stat.out_free;
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |-> $past(o_cmd.rd))
        else $error("evaluate issued without a preceding read");

    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_READ))
        else $error("accepted beat not followed by a read");

    a_hi_put_needs_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put_hi |-> i_stat.mask_hi_nz)
        else $error("upper mask result issued with an empty mask");

endmodule

/* rtl/core/mcst_dp.sv */
// ----------------------------------------------------------------------------
// mcst_dp
// Datapath for the tracker: message decode, note and controller memories,
// per-channel program / bend / pressure registers, active note count,
// popcount for channel clears and the output register.
// ----------------------------------------------------------------------------
module mcst_dp
    import mcst_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]            i_status_byte,
    input  logic [6:0]            i_data_first,
    input  logic [6:0]            i_data_second,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [2:0]            o_kind,
    output logic [3:0]            o_chan,
    output logic [6:0]            o_number,
    output logic [13:0]           o_new_value,
    output logic                  o_present,
    output logic [HALF_W-1:0]     o_off_mask,
    output logic                  o_upper_half,
    output logic [CNT_W-1:0]      o_active_count,
    output logic                  o_last
);

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CTL_DEPTH = NUM_CHANNELS * NOTES_PER_CH;
    localparam int CTL_AW    = CH_W + 7;
    localparam int ROWS      = NUM_CHANNELS * 2;
    localparam int ROW_AW    = CH_W + 1;
    localparam int CHUNKS    = NOTES_PER_CH / POP_W;
    localparam int CHUNK_W   = $clog2(CHUNKS);
    localparam int PC_W      = $clog2(POP_W + 1);

    function automatic logic [PC_W-1:0] popcount8(input logic [POP_W-1:0] v);
        logic [PC_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < POP_W; k++) begin
            acc = acc + PC_W'(v[k]);
        end
        return acc;
    endfunction

    // configuration
    logic r_track_notes;
    logic r_track_controls;
    logic r_track_programs;

    // captured message
    logic [3:0] r_chan;
    logic [6:0] r_d1;
    logic [6:0] r_d2;
    logic [2:0] r_op;
    logic [2:0] n_op;

    // storage
    logic [HALF_W-1:0] r_row_mem [ROWS];
    logic              r_row_vld [ROWS];
    logic [6:0]        r_vel_mem [CTL_DEPTH];
    logic [7:0]        r_ctl_mem [CTL_DEPTH];
    logic [7:0]        r_prog    [NUM_CHANNELS];
    logic [7:0]        r_press   [NUM_CHANNELS];
    logic [13:0]       r_bend    [NUM_CHANNELS];
    logic [CNT_W-1:0]  r_cnt;

    // read data
    logic [HALF_W-1:0] r_row_rd;
    logic              r_row_rd_ok;
    logic [6:0]        r_vel_rd;
    logic [7:0]        r_ctl_rd;

    // pending single result
    logic [2:0]  r_res_kind;
    logic [6:0]  r_res_num;
    logic [13:0] r_res_val;
    logic        r_res_present;

    // channel clear
    logic [HALF_W-1:0]  r_mask_lo;
    logic [HALF_W-1:0]  r_mask_hi;
    logic [CNT_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_cnt_lo;
    logic [CHUNK_W-1:0] r_chunk;
    logic [CTL_AW-1:0]  r_init_idx;

    logic                r_o_valid;
    logic                out_free;
    logic [CH_W-1:0]     ch_idx;
    logic [CTL_AW-1:0]   msg_addr;
    logic [CTL_AW-1:0]   ctl_wr_addr;
    logic [7:0]          ctl_wr_data;
    logic                ctl_we;
    logic [ROW_AW-1:0]   row_rd_addr;
    logic [ROW_AW-1:0]   row_wr_addr;
    logic                row_rd_half;
    logic                row_we;
    logic [HALF_W-1:0]   row_eff;
    logic [HALF_W-1:0]   row_new;
    logic                note_bit;
    logic [13:0]         bend_in;
    logic                changed;
    logic [2:0]          res_kind;
    logic [6:0]          res_num;
    logic [13:0]         res_val;
    logic                res_present;
    logic [CNT_W-1:0]    cnt_next;
    logic [2*HALF_W-1:0] masks;
    logic [PC_W-1:0]     chunk_pc;
    logic [CNT_W-1:0]    acc_sub;
    logic                ch_ok;
    logic [3:0]          in_type;

    assign ch_idx      = r_chan[CH_W-1:0];
    assign msg_addr    = {ch_idx, r_d1};
    assign bend_in     = {r_d2, r_d1};
    assign out_free    = !r_o_valid || !i_stall;
    assign in_type     = i_status_byte[7:4];
    assign ch_ok       = (32'(i_status_byte[3:0]) < NUM_CHANNELS);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_notes    <= 1'b1;
            r_track_controls <= 1'b1;
            r_track_programs <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRACK_NOTES:    r_track_notes    <= i_cfg_data[0];
                CFG_TRACK_CONTROLS: r_track_controls <= i_cfg_data[0];
                CFG_TRACK_PROGRAMS: r_track_programs <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- decode at accept ----------------
    always_comb begin
        n_op = OP_NONE;
        priority if (!ch_ok) begin
            n_op = OP_NONE;
        end else if (in_type == MSG_NOTE_ON && i_data_second != 7'd0) begin
            n_op = r_track_notes ? OP_NOTE_ON : OP_NONE;
        end else if (in_type == MSG_NOTE_ON || in_type == MSG_NOTE_OFF) begin
            n_op = r_track_notes ? OP_NOTE_OFF : OP_NONE;
        end else if (in_type == MSG_CTRL && (i_data_first == CC_ALL_NOTES_OFF ||
                                             i_data_first == CC_ALL_SOUND_OFF)) begin
            n_op = r_track_notes ? OP_CLEAR : OP_NONE;
        end else if (in_type == MSG_BEND) begin
            n_op = r_track_controls ? OP_BEND : OP_NONE;
        end else if (in_type == MSG_PRESS) begin
            n_op = r_track_controls ? OP_PRESS : OP_NONE;
        end else if (in_type == MSG_PROG) begin
            n_op = r_track_programs ? OP_PROG : OP_NONE;
        end else if (in_type == MSG_CTRL) begin
            n_op = r_track_controls ? OP_CTRL : OP_NONE;
        end else begin
            n_op = OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_NONE;
        end else if (i_cmd.accept) begin
            r_op <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_chan <= i_status_byte[3:0];
            r_d1   <= i_data_first;
            r_d2   <= i_data_second;
        end
    end

    // ---------------- note rows (64 activity bits per half channel) ----------------
    // clears only drop the row valid bit, so a row reads as zero until rewritten
    assign row_rd_half = i_cmd.clr_rd1 ? 1'b1 : ((r_op == OP_CLEAR) ? 1'b0 : r_d1[6]);
    assign row_rd_addr = {ch_idx, row_rd_half};
    assign row_wr_addr = {ch_idx, r_d1[6]};
    assign row_eff     = r_row_rd_ok ? r_row_rd : '0;
    assign note_bit    = row_eff[r_d1[5:0]];
    assign row_we      = i_cmd.eval && (r_op == OP_NOTE_ON || r_op == OP_NOTE_OFF);

    always_comb begin
        row_new              = row_eff;
        row_new[r_d1[5:0]]   = (r_op == OP_NOTE_ON);
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_wr_addr] <= row_new;
        end
        if (i_cmd.rd || i_cmd.clr_rd1) begin
            r_row_rd <= r_row_mem[row_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_row_vld[r] <= 1'b0;
            end
            r_row_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.rd || i_cmd.clr_rd1) begin
                r_row_rd_ok <= r_row_vld[row_rd_addr];
            end
            if (row_we) begin
                r_row_vld[row_wr_addr] <= 1'b1;
            end else if (i_cmd.pop && r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                r_row_vld[{ch_idx, 1'b0}] <= 1'b0;
                r_row_vld[{ch_idx, 1'b1}] <= 1'b0;
            end
        end
    end

    // ---------------- velocities ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && r_op == OP_NOTE_ON) begin
            r_vel_mem[msg_addr] <= r_d2;
        end
        if (i_cmd.rd) begin
            r_vel_rd <= r_vel_mem[msg_addr];
        end
    end

    // ---------------- controllers (bit 7 = known) ----------------
    assign ctl_we      = i_cmd.init || (i_cmd.eval && r_op == OP_CTRL);
    assign ctl_wr_addr = i_cmd.init ? r_init_idx : msg_addr;
    assign ctl_wr_data = i_cmd.init ?
        {(r_init_idx[6:0] == CC_SUSTAIN || r_init_idx[6:0] == CC_HOLD2), 7'd0} :
        {1'b1, r_d2};

    always_ff @(posedge i_clk) begin
        if (ctl_we) begin
            r_ctl_mem[ctl_wr_addr] <= ctl_wr_data;
        end
        if (i_cmd.rd) begin
            r_ctl_rd <= r_ctl_mem[msg_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_idx <= '0;
        end else if (i_cmd.init) begin
            r_init_idx <= r_init_idx + CTL_AW'(1);
        end
    end

    // ---------------- evaluate ----------------
    always_comb begin
        changed     = 1'b0;
        res_kind    = KIND_NOTE;
        res_num     = r_d1;
        res_val     = '0;
        res_present = 1'b1;
        cnt_next    = r_cnt;
        unique case (r_op)
            OP_NOTE_ON: begin
                changed = !note_bit || (r_vel_rd != r_d2);
                res_val = {7'd0, r_d2};
                if (!note_bit) cnt_next = r_cnt + CNT_W'(1);
            end
            OP_NOTE_OFF: begin
                changed     = note_bit;
                res_present = 1'b0;
                if (note_bit && r_cnt != '0) cnt_next = r_cnt - CNT_W'(1);
            end
            OP_BEND: begin
                changed  = (r_bend[ch_idx] != bend_in);
                res_kind = KIND_BEND;
                res_num  = '0;
                res_val  = bend_in;
            end
            OP_PRESS: begin
                changed  = !r_press[ch_idx][7] || (r_press[ch_idx][6:0] != r_d1);
                res_kind = KIND_PRESSURE;
                res_num  = '0;
                res_val  = {7'd0, r_d1};
            end
            OP_PROG: begin
                changed  = !r_prog[ch_idx][7] || (r_prog[ch_idx][6:0] != r_d1);
                res_kind = KIND_PROGRAM;
                res_num  = '0;
                res_val  = {7'd0, r_d1};
            end
            OP_CTRL: begin
                changed  = !r_ctl_rd[7] || (r_ctl_rd[6:0] != r_d2);
                res_kind = KIND_CTRL;
                res_val  = {7'd0, r_d2};
            end
            default: begin
                changed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_res_kind    <= res_kind;
            r_res_num     <= res_num;
            r_res_val     <= res_val;
            r_res_present <= res_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_prog[c]  <= '0;
                r_press[c] <= '0;
                r_bend[c]  <= BEND_CENTRE;
            end
        end else if (i_cmd.eval) begin
            if (r_op == OP_BEND)  r_bend[ch_idx]  <= bend_in;
            if (r_op == OP_PRESS) r_press[ch_idx] <= {1'b1, r_d1};
            if (r_op == OP_PROG)  r_prog[ch_idx]  <= {1'b1, r_d1};
        end
    end

    // ---------------- channel clear: 8 notes counted a cycle ----------------
    assign masks    = {r_mask_hi, r_mask_lo};
    assign chunk_pc = popcount8(masks[r_chunk * POP_W +: POP_W]);
    assign acc_sub  = (r_acc >= CNT_W'(chunk_pc)) ? (r_acc - CNT_W'(chunk_pc)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_rd1) begin
            r_mask_lo <= row_eff;
        end
        if (i_cmd.clr_cap) begin
            r_mask_hi <= row_eff;
            r_acc     <= r_cnt;
        end else if (i_cmd.pop) begin
            r_acc <= acc_sub;
            if (r_chunk == CHUNK_W'(CHUNKS / 2 - 1)) begin
                r_cnt_lo <= acc_sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.clr_cap) begin
                r_chunk <= '0;
            end else if (i_cmd.pop) begin
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
            if (i_cmd.eval) begin
                r_cnt <= cnt_next;
            end else if (i_cmd.pop && r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                r_cnt <= acc_sub;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.put || i_cmd.put_lo || i_cmd.put_hi) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            o_kind         <= r_res_kind;
            o_chan         <= r_chan;
            o_number       <= r_res_num;
            o_new_value    <= r_res_val;
            o_present      <= r_res_present;
            o_off_mask     <= '0;
            o_upper_half   <= 1'b0;
            o_active_count <= r_cnt;
            o_last         <= 1'b1;
        end else if (i_cmd.put_lo || i_cmd.put_hi) begin
            o_kind         <= KIND_OFF_MASK;
            o_chan         <= r_chan;
            o_number       <= '0;
            o_new_value    <= '0;
            o_present      <= 1'b0;
            o_off_mask     <= i_cmd.put_hi ? r_mask_hi : r_mask_lo;
            o_upper_half   <= i_cmd.put_hi;
            o_active_count <= i_cmd.put_hi ? r_cnt : r_cnt_lo;
            o_last         <= i_cmd.put_hi || (r_mask_hi == '0);
        end
    end

    assign o_valid = r_o_valid;

    // ---------------- status ----------------
    assign o_stat.init_last  = (r_init_idx == CTL_AW'(CTL_DEPTH - 1));
    assign o_stat.op_none    = (r_op == OP_NONE);
    assign o_stat.op_clear   = (r_op == OP_CLEAR);
    assign o_stat.changed    = changed;
    assign o_stat.pop_last   = (r_chunk == CHUNK_W'(CHUNKS - 1));
    assign o_stat.mask_lo_nz = (r_mask_lo != '0);
    assign o_stat.mask_hi_nz = (r_mask_hi != '0);
    assign o_stat.out_free   = out_free;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= CTL_DEPTH)
        else $error("active note count above number of notes");

    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && o_kind == KIND_OFF_MASK) |-> (o_off_mask != '0))
        else $error("notes-off result with empty mask");

    a_plain_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && o_kind != KIND_OFF_MASK) |-> (o_off_mask == '0 && !o_upper_half))
        else $error("value result carries mask bits");

endmodule

/* rtl/core/midi_channel_state_tracker_core.sv */
// ----------------------------------------------------------------------------
// midi_channel_state_tracker_core
// Tracks note, controller, program, bend and pressure state of MIDI channels
// and reports every change of a stored value.
// ----------------------------------------------------------------------------
// After reset the block sets up the controller memory, all NUM_CHANNELS*128
// entries (2048 at the default), one entry a cycle, and holds o_stall high
// meanwhile; configuration writes are taken throughout. One message beat is
// worked at a time: accept, memory read, evaluate and update, then the result
// beat goes to the output register once that register is free. A message
// that changes nothing gives no result beat, and an ignored one ends after
// the memory read. An all notes off or all sound off message reads the two
// 64-note rows of the channel, counts the notes that go off 8 per cycle and
// gives up to two mask beats. A new message may be accepted while the last
// result beat still waits on i_stall.
// ----------------------------------------------------------------------------
module midi_channel_state_tracker_core
    import mcst_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_status_byte,
    input  logic [6:0]            i_data_first,
    input  logic [6:0]            i_data_second,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_kind,
    output logic [3:0]            o_chan,
    output logic [6:0]            o_number,
    output logic [13:0]           o_new_value,
    output logic                  o_present,
    output logic [HALF_W-1:0]     o_off_mask,
    output logic                  o_upper_half,
    output logic [CNT_W-1:0]      o_active_count,
    output logic                  o_last
);

    t_cmd  cmd;
    t_stat stat;

    mcst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    mcst_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_status_byte  (i_status_byte),
        .i_data_first   (i_data_first),
        .i_data_second  (i_data_second),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_chan         (o_chan),
        .o_number       (o_number),
        .o_new_value    (o_new_value),
        .o_present      (o_present),
        .o_off_mask     (o_off_mask),
        .o_upper_half   (o_upper_half),
        .o_active_count (o_active_count),
        .o_last         (o_last)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MIDI channel state tracker core. A behavioural
// copy of the channel state predicts the change beats of every accepted
// message; a checker process compares each output beat in order. Directed
// cases, tracking-enable modes, random traffic with idling on both sides and
// a long output hold-off are run in turn.
// ----------------------------------------------------------------------------
module tb;
    import mcst_pkg::*;

    localparam int         NCH           = NUM_CHANNELS_DEF;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         SETTLE_CYCLES = 32;
    localparam logic [3:0] MSG_POLY_PRESS = 4'hA;
    localparam logic [3:0] MSG_SYSTEM     = 4'hF;

    typedef struct {
        logic [2:0]       kind;
        logic [3:0]       chan;
        logic [6:0]       number;
        logic [13:0]      value;
        logic             present;
        logic [63:0]      mask;
        logic             upper;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_change;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_status_byte = '0;
    logic [6:0]            i_data_first = '0;
    logic [6:0]            i_data_second = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b1;
    logic [2:0]            o_kind;
    logic [3:0]            o_chan;
    logic [6:0]            o_number;
    logic [13:0]           o_new_value;
    logic                  o_present;
    logic [HALF_W-1:0]     o_off_mask;
    logic                  o_upper_half;
    logic [CNT_W-1:0]      o_active_count;
    logic                  o_last;

    // channel state copy
    logic [7:0]       vel_mem [NCH*128];
    logic [7:0]       ctrl_mem [NCH*128];
    logic [7:0]       prog_mem [NCH];
    logic [13:0]      bend_mem [NCH];
    logic [7:0]       press_mem [NCH];
    int               active_notes;
    logic             en_notes, en_controls, en_programs;

    t_change          pending_changes [$];
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    int               hold_left = 0;
    int               errors = 0;
    int               msgs_sent = 0;
    int               beats_checked = 0;
    int               mask_beats = 0;
    int               cycles = 0;

    midi_channel_state_tracker_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d changes still pending", $realtime,
                     pending_changes.size());
            $display("midi_channel_state_tracker_core regression: fail");
            $finish;
        end
    end

    function automatic t_change make_change(logic [2:0] kind, logic [3:0] ch,
                                            logic [6:0] num, logic [13:0] val,
                                            logic pres, logic [63:0] mask,
                                            logic upper);
        t_change c;
        c.kind    = kind;
        c.chan    = ch;
        c.number  = num;
        c.value   = val;
        c.present = pres;
        c.mask    = mask;
        c.upper   = upper;
        c.count   = active_notes[CNT_W-1:0];
        c.last    = 1'b0;
        return c;
    endfunction

    function automatic void reset_state();
        for (int i = 0; i < NCH*128; i++) begin
            vel_mem[i]  = 8'h00;
            ctrl_mem[i] = ((i % 128) == CC_SUSTAIN || (i % 128) == CC_HOLD2) ? 8'h80 : 8'h00;
        end
        for (int c = 0; c < NCH; c++) begin
            prog_mem[c]  = 8'h00;
            bend_mem[c]  = BEND_CENTRE;
            press_mem[c] = 8'h00;
        end
        active_notes = 0;
        en_notes     = 1'b1;
        en_controls  = 1'b1;
        en_programs  = 1'b1;
    endfunction

    // works out the change beats one message causes and updates the state
    function automatic void predict_changes(logic [7:0] status, logic [6:0] d1,
                                            logic [6:0] d2);
        t_change    batch [$];
        logic [3:0] mtype;
        logic [3:0] ch;
        int         idx;
        logic [7:0] nv;
        logic [13:0] bv;
        logic [63:0] mask;
        mtype = status[7:4];
        ch    = status[3:0];
        idx   = int'(ch) * 128 + int'(d1);
        nv    = {1'b1, d2};
        if (int'(ch) >= NCH) return;
        if (mtype == MSG_NOTE_ON && d2 != 0) begin
            if (en_notes) begin
                if (!vel_mem[idx][7]) active_notes++;
                if (vel_mem[idx] != nv)
                    batch.insert(batch.size(),
                                 make_change(KIND_NOTE, ch, d1, 14'(d2), 1'b1, '0, 1'b0));
                vel_mem[idx] = nv;
            end
        end else if (mtype == MSG_NOTE_OFF || mtype == MSG_NOTE_ON) begin
            if (en_notes) begin
                if (vel_mem[idx][7]) begin
                    if (active_notes > 0) active_notes--;
                    batch.insert(batch.size(),
                                 make_change(KIND_NOTE, ch, d1, '0, 1'b0, '0, 1'b0));
                end
                vel_mem[idx] = 8'h00;
            end
        end else if (mtype == MSG_CTRL && (d1 == CC_ALL_NOTES_OFF || d1 == CC_ALL_SOUND_OFF)) begin
            if (en_notes) begin
                for (int half = 0; half < 2; half++) begin
                    mask = '0;
                    for (int i = 0; i < 64; i++) begin
                        if (vel_mem[int'(ch)*128 + half*64 + i][7]) begin
                            mask[i] = 1'b1;
                            if (active_notes > 0) active_notes--;
                        end
                        vel_mem[int'(ch)*128 + half*64 + i] = 8'h00;
                    end
                    if (mask != 0)
                        batch.insert(batch.size(),
                                     make_change(KIND_OFF_MASK, ch, '0, '0, 1'b0, mask,
                                                 half[0]));
                end
            end
        end else if (mtype == MSG_BEND) begin
            if (en_controls) begin
                bv = {d2, d1};
                if (bend_mem[ch] != bv)
                    batch.insert(batch.size(),
                                 make_change(KIND_BEND, ch, '0, bv, 1'b1, '0, 1'b0));
                bend_mem[ch] = bv;
            end
        end else if (mtype == MSG_PRESS) begin
            if (en_controls) begin
                nv = {1'b1, d1};
                if (press_mem[ch] != nv)
                    batch.insert(batch.size(),
                                 make_change(KIND_PRESSURE, ch, '0, 14'(d1), 1'b1, '0, 1'b0));
                press_mem[ch] = nv;
            end
        end else if (mtype == MSG_PROG) begin
            if (en_programs) begin
                nv = {1'b1, d1};
                if (prog_mem[ch] != nv)
                    batch.insert(batch.size(),
                                 make_change(KIND_PROGRAM, ch, '0, 14'(d1), 1'b1, '0, 1'b0));
                prog_mem[ch] = nv;
            end
        end else if (mtype == MSG_CTRL) begin
            if (en_controls) begin
                if (ctrl_mem[idx] != nv)
                    batch.insert(batch.size(),
                                 make_change(KIND_CTRL, ch, d1, 14'(d2), 1'b1, '0, 1'b0));
                ctrl_mem[idx] = nv;
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[k]) pending_changes.insert(pending_changes.size(), batch[k]);
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            errors++;
            $display("%0t mismatch on %s: expected %h, actual %h", $realtime, name,
                     exp_val, act_val);
        end
    endtask

    // output side: compare each beat, then decide the stall for the next edge
    always @(posedge i_clk) begin
        t_change c;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_changes.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none, actual kind %0d chan %0d",
                         $realtime, o_kind, o_chan);
            end else begin
                c = pending_changes.pop_front();
                beats_checked++;
                if (c.kind == KIND_OFF_MASK) mask_beats++;
                check_field("kind", 64'(c.kind), 64'(o_kind));
                check_field("chan", 64'(c.chan), 64'(o_chan));
                check_field("number", 64'(c.number), 64'(o_number));
                check_field("new_value", 64'(c.value), 64'(o_new_value));
                check_field("present", 64'(c.present), 64'(o_present));
                check_field("off_mask", c.mask, o_off_mask);
                check_field("upper_half", 64'(c.upper), 64'(o_upper_half));
                check_field("active_count", 64'(c.count), 64'(o_active_count));
                check_field("last", 64'(c.last), 64'(o_last));
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_TRACK_NOTES:    en_notes = data[0];
            CFG_TRACK_CONTROLS: en_controls = data[0];
            CFG_TRACK_PROGRAMS: en_programs = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one message beat; valid stays up into the next call unless a gap is drawn
    task automatic send_msg(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
        i_valid       <= 1'b1;
        i_status_byte <= status;
        i_data_first  <= d1;
        i_data_second <= d2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_changes(status, d1, d2);
        msgs_sent++;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_changes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed traffic on a few channels and notes so that state repeats
    task automatic send_random_msgs(int count);
        int         done;
        int         pick;
        logic [3:0] ch;
        logic [6:0] n1, n2;
        logic [3:0] mtype;
        logic [7:0] status;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            ch   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                                 4'($urandom_range(0, 2));
            n1   = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 127)) :
                                                 7'($urandom_range(60, 67));
            case ($urandom_range(0, 9))
                0:       n2 = 7'd0;
                1, 2:    n2 = 7'($urandom_range(1, 2));
                default: n2 = 7'($urandom_range(0, 127));
            endcase
            if (pick < 30) begin
                mtype = MSG_NOTE_ON;
            end else if (pick < 45) begin
                mtype = MSG_NOTE_OFF;
            end else if (pick < 50) begin
                mtype = MSG_CTRL;
                n1 = $urandom_range(0, 1) ? CC_ALL_NOTES_OFF : CC_ALL_SOUND_OFF;
            end else if (pick < 65) begin
                mtype = MSG_CTRL;
                case ($urandom_range(0, 4))
                    0: n1 = CC_SUSTAIN;
                    1: n1 = CC_HOLD2;
                    2: n1 = 7'd7;
                    default: n1 = 7'($urandom_range(0, 127));
                endcase
            end else if (pick < 73) begin
                mtype = MSG_BEND;
                if ($urandom_range(0, 3) == 0) begin
                    n1 = 7'd0;
                    n2 = 7'd64;
                end
            end else if (pick < 81) begin
                mtype = MSG_PRESS;
                if ($urandom_range(0, 1)) n1 = 7'($urandom_range(0, 3));
            end else if (pick < 89) begin
                mtype = MSG_PROG;
                if ($urandom_range(0, 1)) n1 = 7'($urandom_range(0, 3));
            end else begin
                mtype = 4'($urandom_range(0, 15));
            end
            status = {mtype, ch};
            if (pick >= 89) begin
                status = 8'($urandom_range(0, 255));
                n1     = 7'($urandom_range(0, 127));
                n2     = 7'($urandom_range(0, 127));
            end else begin
                done++;
            end
            send_msg(status, n1, n2);
        end
    endtask

    task automatic test_directed();
        send_msg({MSG_NOTE_ON, 4'd0}, 7'd0, 7'd127);    // first note after inactive
        send_msg({MSG_NOTE_ON, 4'd0}, 7'd0, 7'd127);    // same velocity, no change
        send_msg({MSG_NOTE_ON, 4'd0}, 7'd0, 7'd1);
        send_msg({MSG_NOTE_ON, 4'd15}, 7'd127, 7'd1);
        send_msg({MSG_NOTE_OFF, 4'd0}, 7'd0, 7'd127);
        send_msg({MSG_NOTE_OFF, 4'd0}, 7'd0, 7'd0);     // already off
        send_msg({MSG_NOTE_ON, 4'd15}, 7'd127, 7'd0);   // zero velocity counts as off
        send_msg({MSG_NOTE_ON, 4'd3}, 7'd5, 7'd64);
        send_msg({MSG_NOTE_ON, 4'd3}, 7'd70, 7'd64);
        send_msg({MSG_CTRL, 4'd3}, CC_ALL_NOTES_OFF, 7'd0);  // both halves
        send_msg({MSG_CTRL, 4'd3}, CC_ALL_SOUND_OFF, 7'd0);  // nothing left on
        send_msg({MSG_NOTE_ON, 4'd2}, 7'd10, 7'd100);
        send_msg({MSG_CTRL, 4'd2}, CC_ALL_SOUND_OFF, 7'd127);
        send_msg({MSG_CTRL, 4'd1}, CC_SUSTAIN, 7'd0);        // known zero after reset
        send_msg({MSG_CTRL, 4'd1}, CC_SUSTAIN, 7'd127);
        send_msg({MSG_CTRL, 4'd1}, 7'd7, 7'd0);              // unknown controller
        send_msg({MSG_CTRL, 4'd1}, CC_HOLD2, 7'd0);
        send_msg({MSG_BEND, 4'd4}, 7'd0, 7'd64);             // centre, no change
        send_msg({MSG_BEND, 4'd4}, 7'd127, 7'd127);
        send_msg({MSG_BEND, 4'd4}, 7'd0, 7'd0);
        send_msg({MSG_PRESS, 4'd5}, 7'd0, 7'd0);
        send_msg({MSG_PRESS, 4'd5}, 7'd0, 7'd99);
        send_msg({MSG_PROG, 4'd6}, 7'd0, 7'd0);
        send_msg({MSG_PROG, 4'd6}, 7'd127, 7'd0);
        send_msg({MSG_POLY_PRESS, 4'd0}, 7'd60, 7'd60);      // ignored kinds
        send_msg({MSG_SYSTEM, 4'd8}, 7'd1, 7'd2);
        send_msg(8'h7F, 7'd127, 7'd127);
        drain();
    endtask

    task automatic run_mode(logic notes, logic controls, logic programs, int count);
        write_reg(CFG_TRACK_NOTES, notes);
        write_reg(CFG_TRACK_CONTROLS, controls);
        write_reg(CFG_TRACK_PROGRAMS, programs);
        send_random_msgs(count);
        drain();
    endtask

    task automatic test_track_modes();
        tx_idle_pct  = 10;
        rx_stall_pct = 20;
        run_mode(1'b0, 1'b0, 1'b0, 25);
        run_mode(1'b1, 1'b0, 1'b1, 25);
        run_mode(1'b0, 1'b1, 1'b0, 25);
        run_mode(1'b1, 1'b1, 1'b1, 25);
    endtask

    task automatic test_random_traffic();
        tx_idle_pct  = 16;
        rx_stall_pct = 61;
        send_random_msgs(100);
        drain();
        tx_idle_pct  = 61;
        rx_stall_pct = 16;
        send_random_msgs(100);
        drain();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random_msgs(100);
        drain();
    endtask

    // output held off for a long stretch while messages keep coming
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = 300;
        send_random_msgs(40);
        drain();
    endtask

    initial begin
        reset_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_track_modes();
        test_random_traffic();
        test_backpressure();
        $display("covered %0d messages, %0d change beats checked, %0d of them off masks",
                 msgs_sent, beats_checked, mask_beats);
        $display("tracking modes, idling on both sides and a long output hold-off included");
        if (errors == 0)
            $display("midi_channel_state_tracker_core regression: pass");
        else
            $display("midi_channel_state_tracker_core regression: fail");
        $finish;
    end

endmodule

/* midi_channel_state_tracker_core.f */
rtl/core/mcst_pkg.sv
rtl/core/mcst_ctrl.sv
rtl/core/mcst_dp.sv
rtl/core/midi_channel_state_tracker_core.sv
dv/tb.sv
